/* design/apm_pkg.sv */
// ----------------------------------------------------------------------------
// apm_pkg: shared types and constants of the averaging panel meter
// Transaction payloads, command queue entries and fixed field widths.
// ----------------------------------------------------------------------------
package apm_pkg;

  localparam int SAMPLE_W    = 10;
  localparam int SUM_W       = 16;
  localparam int COUNT_W     = 6;
  localparam int READING_W   = 10;
  localparam int DIGIT_W     = 4;
  localparam int ENABLE_W    = 3;
  localparam int SCAN_W      = 2;
  localparam int SCALE_W     = 24;
  localparam int SCALE_FRAC  = 16;
  localparam int RECIP_SHIFT = 22;
  localparam int QUEUE_DEPTH = 2;

  localparam int AVG_COUNT_DEFAULT = 50;

  localparam logic [READING_W-1:0] READING_MAX = 10'd999;
  localparam logic [SCALE_W-1:0]   SCALE_RESET = 24'd3203;

  localparam logic [ENABLE_W-1:0] ENABLE_OFF      = 3'b000;
  localparam logic [ENABLE_W-1:0] ENABLE_ONES     = 3'b001;
  localparam logic [ENABLE_W-1:0] ENABLE_TENS     = 3'b010;
  localparam logic [ENABLE_W-1:0] ENABLE_HUNDREDS = 3'b100;

  localparam logic [SCAN_W-1:0] SCAN_ONES     = 2'd0;
  localparam logic [SCAN_W-1:0] SCAN_TENS     = 2'd1;
  localparam logic [SCAN_W-1:0] SCAN_HUNDREDS = 2'd2;

  localparam logic ACTION_SAMPLE = 1'b0;
  localparam logic ACTION_TICK   = 1'b1;

  typedef struct packed {
    logic                action;
    logic [SAMPLE_W-1:0] sample;
  } in_t;

  typedef struct packed {
    logic [DIGIT_W-1:0]   display_digit;
    logic [ENABLE_W-1:0]  digit_enable;
    logic [READING_W-1:0] reading;
    logic                 new_reading;
  } out_t;

  typedef enum logic [1:0] {
    CMD_PLAIN = 2'd0,
    CMD_AVG   = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [SUM_W-1:0]   sum;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_CORR  = 2'd1,
    BK_SCALE = 2'd2,
    BK_SAT   = 2'd3
  } back_state_t;

endpackage

/* design/averaging_panel_meter_display.sv */
// ----------------------------------------------------------------------------
// averaging_panel_meter_display: averaging panel meter with digit scan
// Boxcar average of converter samples, scaled to tenths of a volt, shown on a
// three-digit multiplexed BCD display.
//
//   Channel   Direction  Handshake              Payload
//   in        input      in_valid / in_ready    apm_pkg::in_t
//   out       output     out_valid / out_ready  apm_pkg::out_t
//   cfg       input      cfg_valid / cfg_ready  scale_factor, 24 bits
//
// A sample that does not complete an average and a scan tick are each handled
// in the idle state; a sample that completes an average passes on through the
// divide-by-count correction, the scale multiply and the saturation steps.
// The input is taken every cycle while the two-entry command queue has room.
// Reset is synchronous, clears the sum, count, reading and scan, and loads the
// default scale.
// A stalled output holds its transaction and the back end waits on it.
// ----------------------------------------------------------------------------
module averaging_panel_meter_display #(
  parameter int AVG_COUNT = apm_pkg::AVG_COUNT_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  apm_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output apm_pkg::out_t               out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [apm_pkg::SCALE_W-1:0] cfg_data
);

  logic          push;
  apm_pkg::cmd_t push_cmd;
  logic          queue_full;
  logic          pop;
  logic          head_valid;
  apm_pkg::cmd_t head_cmd;

  apm_front #(
    .AVG_COUNT (AVG_COUNT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  apm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  apm_back #(
    .AVG_COUNT (AVG_COUNT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

/* design/apm_front.sv */
// ----------------------------------------------------------------------------
// apm_front: input side of the panel meter
// Accepts transactions, accumulates samples and issues one command per item.
// ----------------------------------------------------------------------------
module apm_front #(
  parameter int AVG_COUNT = apm_pkg::AVG_COUNT_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  apm_pkg::in_t  in_data,
  input  logic          queue_full,
  output logic          push,
  output apm_pkg::cmd_t push_cmd
);

  localparam logic [apm_pkg::COUNT_W-1:0] LastCount = apm_pkg::COUNT_W'(AVG_COUNT - 1);

  logic [apm_pkg::SUM_W-1:0]   sample_sum;
  logic [apm_pkg::COUNT_W-1:0] sample_count;
  logic [apm_pkg::SUM_W-1:0]   sum_added;
  logic                        complete;

  assign in_ready  = !queue_full;
  assign push      = in_valid && in_ready;
  assign sum_added = sample_sum + apm_pkg::SUM_W'(in_data.sample);
  assign complete  = (sample_count >= LastCount);

  always_comb begin
    push_cmd.sum = sum_added;
    if (in_data.action == apm_pkg::ACTION_TICK) begin
      push_cmd.kind = apm_pkg::CMD_TICK;
    end else if (complete) begin
      push_cmd.kind = apm_pkg::CMD_AVG;
    end else begin
      push_cmd.kind = apm_pkg::CMD_PLAIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
    end else if (push && in_data.action == apm_pkg::ACTION_SAMPLE) begin
      if (complete) begin
        sample_sum   <= '0;
        sample_count <= '0;
      end else begin
        sample_sum   <= sum_added;
        sample_count <= sample_count + 1'b1;
      end
    end
  end

endmodule

/* design/apm_queue.sv */
// ----------------------------------------------------------------------------
// apm_queue: short command queue between front and back
// Lets the input side keep accepting while the back end works or stalls.
// ----------------------------------------------------------------------------
module apm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  apm_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output apm_pkg::cmd_t head_cmd
);

  localparam int PtrW = $clog2(apm_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(apm_pkg::QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(apm_pkg::QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(apm_pkg::QUEUE_DEPTH);

  apm_pkg::cmd_t   entries [apm_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;

  assign full       = (fill == DepthCnt);
  assign head_valid = (fill != '0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* design/apm_back.sv */
// ----------------------------------------------------------------------------
// apm_back: execution side of the panel meter
// Averages, scales and saturates readings, scans digits, holds the result.
// ----------------------------------------------------------------------------
module apm_back #(
  parameter int AVG_COUNT = apm_pkg::AVG_COUNT_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [apm_pkg::SCALE_W-1:0] cfg_data,
  input  logic                        head_valid,
  input  apm_pkg::cmd_t               head_cmd,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output apm_pkg::out_t               out_data
);

  localparam int RecipW = apm_pkg::RECIP_SHIFT + 1;
  localparam int DivW   = apm_pkg::SUM_W + RecipW;
  localparam int NW     = 7;
  localparam int MulW   = apm_pkg::SUM_W + apm_pkg::SCALE_W;
  localparam logic [RecipW-1:0] Recip = RecipW'((1 << apm_pkg::RECIP_SHIFT) / AVG_COUNT);
  localparam logic [NW-1:0] Divisor = NW'(AVG_COUNT);

  apm_pkg::back_state_t state;
  apm_pkg::back_state_t state_next;

  logic [apm_pkg::SCALE_W-1:0]   scale_factor;
  logic [apm_pkg::SUM_W-1:0]     sum_hold;
  logic [DivW-1:0]               div_prod;
  logic [apm_pkg::SUM_W-1:0]     average;
  logic [MulW-1:0]               scale_prod;
  logic [apm_pkg::READING_W-1:0] latest_reading;
  logic [apm_pkg::SCAN_W-1:0]    scan_position;
  logic [apm_pkg::DIGIT_W-1:0]   driven_digit;
  logic [apm_pkg::ENABLE_W-1:0]  driven_enable;

  logic                          out_free;
  logic                          finish;
  logic [apm_pkg::SUM_W-1:0]     quot_est;
  logic [apm_pkg::SUM_W+NW-1:0]  quot_times_n;
  logic [apm_pkg::SUM_W-1:0]     remainder;
  logic [apm_pkg::SUM_W-1:0]     quot_fixed;
  logic [apm_pkg::SCALE_W-1:0]   scaled;
  logic [apm_pkg::READING_W-1:0] saturated;

  logic [17:0]                   tens_prod;
  logic [15:0]                   hund_prod;
  logic [6:0]                    tens_quot;
  logic [3:0]                    hund_quot;
  logic [apm_pkg::DIGIT_W-1:0]   digit_ones;
  logic [apm_pkg::DIGIT_W-1:0]   digit_tens;
  logic [apm_pkg::DIGIT_W-1:0]   tick_digit;
  logic [apm_pkg::ENABLE_W-1:0]  tick_enable;
  logic [apm_pkg::SCAN_W-1:0]    tick_position;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    finish     = 1'b0;
    unique case (state)
      apm_pkg::BK_IDLE: begin
        if (head_valid && out_free) begin
          pop = 1'b1;
          if (head_cmd.kind == apm_pkg::CMD_AVG) begin
            state_next = apm_pkg::BK_CORR;
          end
        end
      end
      apm_pkg::BK_CORR: begin
        state_next = apm_pkg::BK_SCALE;
      end
      apm_pkg::BK_SCALE: begin
        state_next = apm_pkg::BK_SAT;
      end
      apm_pkg::BK_SAT: begin
        finish     = 1'b1;
        state_next = apm_pkg::BK_IDLE;
      end
      default: begin
        state_next = apm_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apm_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Reciprocal estimate is at most one low; one compare fixes it.
  assign quot_est     = div_prod[apm_pkg::RECIP_SHIFT +: apm_pkg::SUM_W];
  assign quot_times_n = (apm_pkg::SUM_W+NW)'(quot_est) * (apm_pkg::SUM_W+NW)'(Divisor);
  assign remainder    = sum_hold - quot_times_n[apm_pkg::SUM_W-1:0];
  assign quot_fixed   = (remainder >= apm_pkg::SUM_W'(Divisor)) ? quot_est + 1'b1 : quot_est;

  assign scaled    = scale_prod[apm_pkg::SCALE_FRAC +: apm_pkg::SCALE_W];
  assign saturated = (scaled > apm_pkg::SCALE_W'(apm_pkg::READING_MAX)) ?
                     apm_pkg::READING_MAX : scaled[apm_pkg::READING_W-1:0];

  // Digit split of a reading below one thousand by reciprocal multiplies.
  assign tens_prod  = 18'(latest_reading) * 18'd205;
  assign hund_prod  = 16'(latest_reading) * 16'd41;
  assign tens_quot  = tens_prod[17:11];
  assign hund_quot  = hund_prod[15:12];
  assign digit_ones = apm_pkg::DIGIT_W'(latest_reading - 10'(tens_quot) * 10'd10);
  assign digit_tens = apm_pkg::DIGIT_W'(tens_quot - 7'(hund_quot) * 7'd10);

  always_comb begin
    tick_digit    = driven_digit;
    tick_enable   = apm_pkg::ENABLE_OFF;
    tick_position = apm_pkg::SCAN_ONES;
    unique case (scan_position)
      apm_pkg::SCAN_ONES: begin
        tick_digit    = digit_ones;
        tick_enable   = apm_pkg::ENABLE_ONES;
        tick_position = apm_pkg::SCAN_TENS;
      end
      apm_pkg::SCAN_TENS: begin
        tick_digit    = digit_tens;
        tick_enable   = apm_pkg::ENABLE_TENS;
        tick_position = apm_pkg::SCAN_HUNDREDS;
      end
      apm_pkg::SCAN_HUNDREDS: begin
        tick_digit    = hund_quot;
        tick_enable   = apm_pkg::ENABLE_HUNDREDS;
        tick_position = apm_pkg::SCAN_ONES;
      end
      default: begin
        tick_digit    = driven_digit;
        tick_enable   = apm_pkg::ENABLE_OFF;
        tick_position = apm_pkg::SCAN_ONES;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop && head_cmd.kind == apm_pkg::CMD_AVG) begin
      sum_hold <= head_cmd.sum;
      div_prod <= DivW'(head_cmd.sum) * DivW'(Recip);
    end
    if (state == apm_pkg::BK_CORR) begin
      average <= quot_fixed;
    end
    if (state == apm_pkg::BK_SCALE) begin
      scale_prod <= MulW'(average) * MulW'(scale_factor);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor   <= apm_pkg::SCALE_RESET;
      latest_reading <= '0;
      scan_position  <= apm_pkg::SCAN_ONES;
      driven_digit   <= '0;
      driven_enable  <= apm_pkg::ENABLE_OFF;
    end else begin
      if (cfg_valid && cfg_ready) begin
        scale_factor <= cfg_data;
      end
      if (finish) begin
        latest_reading <= saturated;
      end
      if (pop && head_cmd.kind == apm_pkg::CMD_TICK) begin
        scan_position <= tick_position;
        driven_digit  <= tick_digit;
        driven_enable <= tick_enable;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish || (pop && head_cmd.kind != apm_pkg::CMD_AVG)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data.display_digit <= driven_digit;
      out_data.digit_enable  <= driven_enable;
      out_data.reading       <= saturated;
      out_data.new_reading   <= 1'b1;
    end else if (pop && head_cmd.kind == apm_pkg::CMD_TICK) begin
      out_data.display_digit <= tick_digit;
      out_data.digit_enable  <= tick_enable;
      out_data.reading       <= latest_reading;
      out_data.new_reading   <= 1'b0;
    end else if (pop && head_cmd.kind != apm_pkg::CMD_AVG) begin
      out_data.display_digit <= driven_digit;
      out_data.digit_enable  <= driven_enable;
      out_data.reading       <= latest_reading;
      out_data.new_reading   <= 1'b0;
    end
  end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench of the averaging panel meter display
// Sends converter samples, scan ticks and scale writes over valid/ready
// channels with random gaps and output stalls. Each output transaction is
// checked field by field against an internal model of the meter.
// ----------------------------------------------------------------------------
module tb;
  import apm_pkg::*;

  localparam int AVG_N  = AVG_COUNT_DEFAULT;
  localparam int PROD_W = SCALE_W + SUM_W;

  typedef enum logic [1:0] {JOB_ITEM, JOB_SCALE, JOB_PAUSE, JOB_IDLING} job_kind_t;
  typedef enum logic [1:0] {FILL_ZERO, FILL_FULL, FILL_RANDOM, FILL_LEVEL} fill_t;

  typedef struct {
    job_kind_t          kind;
    in_t                item;
    logic [SCALE_W-1:0] scale;
    logic               idling;
  } job_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  in_t                in_data;
  logic               out_valid;
  logic               out_ready;
  out_t               out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [SCALE_W-1:0] cfg_data;

  job_t jobs[$];
  out_t expected_readouts[$];
  int   errors;
  int   n_in_sent;
  int   n_in_taken;
  int   n_cfg_sent;
  int   n_cfg_taken;
  int   n_out_taken;
  int   n_out_seen;
  int   in_gap;
  int   out_stall;
  logic idling_on;

  logic [SUM_W-1:0]     acc_sum;
  logic [COUNT_W-1:0]   acc_count;
  logic [READING_W-1:0] shown_reading;
  logic [SCAN_W-1:0]    scan_pos;
  logic [DIGIT_W-1:0]   lit_digit;
  logic [ENABLE_W-1:0]  lit_enable;
  logic [SCALE_W-1:0]   scale_q816;

  averaging_panel_meter_display #(
    .AVG_COUNT(AVG_N)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic out_t meter_response(in_t item);
    logic [SUM_W-1:0]  average;
    logic [PROD_W-1:0] product;
    out_t              r;
    r.new_reading = 1'b0;
    if (item.action == ACTION_SAMPLE) begin
      acc_sum = acc_sum + SUM_W'(item.sample);
      if (acc_count >= COUNT_W'(AVG_N - 1)) begin
        average = acc_sum / SUM_W'(AVG_N);
        product = (PROD_W'(average) * PROD_W'(scale_q816)) >> SCALE_FRAC;
        shown_reading = (product > PROD_W'(READING_MAX)) ? READING_MAX
                                                         : product[READING_W-1:0];
        acc_sum = '0;
        acc_count = '0;
        r.new_reading = 1'b1;
      end else begin
        acc_count = acc_count + 1'b1;
      end
    end else begin
      case (scan_pos)
        SCAN_ONES: begin
          lit_digit = DIGIT_W'(shown_reading % 10);
          lit_enable = ENABLE_ONES;
          scan_pos = SCAN_TENS;
        end
        SCAN_TENS: begin
          lit_digit = DIGIT_W'((shown_reading / 10) % 10);
          lit_enable = ENABLE_TENS;
          scan_pos = SCAN_HUNDREDS;
        end
        SCAN_HUNDREDS: begin
          lit_digit = DIGIT_W'((shown_reading / 100) % 10);
          lit_enable = ENABLE_HUNDREDS;
          scan_pos = SCAN_ONES;
        end
        default: begin
          lit_enable = ENABLE_OFF;
          scan_pos = SCAN_ONES;
        end
      endcase
    end
    r.display_digit = lit_digit;
    r.digit_enable = lit_enable;
    r.reading = shown_reading;
    return r;
  endfunction

  task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch, got %0d expected %0d", $time, field, got, want);
    errors++;
  endtask

  task automatic add_item(logic action, logic [SAMPLE_W-1:0] value);
    job_t j;
    j.kind = JOB_ITEM;
    j.item.action = action;
    j.item.sample = value;
    j.scale = '0;
    j.idling = 1'b0;
    jobs.push_back(j);
  endtask

  task automatic add_control(job_kind_t kind, logic [SCALE_W-1:0] scale, logic idling);
    job_t j;
    j.kind = kind;
    j.item = '0;
    j.scale = scale;
    j.idling = idling;
    jobs.push_back(j);
  endtask

  task automatic add_window(fill_t fill);
    logic [SAMPLE_W-1:0] level;
    logic [SAMPLE_W-1:0] value;
    level = SAMPLE_W'($urandom_range(0, 1023));
    for (int k = 0; k < AVG_N; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        add_item(ACTION_TICK, SAMPLE_W'($urandom_range(0, 1023)));
      end
      case (fill)
        FILL_ZERO: value = '0;
        FILL_FULL: value = '1;
        FILL_RANDOM: value = SAMPLE_W'($urandom_range(0, 1023));
        default: value = level ^ SAMPLE_W'($urandom_range(0, 7));
      endcase
      add_item(ACTION_SAMPLE, value);
    end
  endtask

  initial begin
    logic [SCALE_W-1:0] s;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    errors = 0;
    n_in_sent = 0;
    n_in_taken = 0;
    n_cfg_sent = 0;
    n_cfg_taken = 0;
    n_out_taken = 0;
    n_out_seen = 0;
    in_gap = 0;
    out_stall = 0;
    idling_on = 1'b1;
    acc_sum = '0;
    acc_count = '0;
    shown_reading = '0;
    scan_pos = SCAN_ONES;
    lit_digit = '0;
    lit_enable = ENABLE_OFF;
    scale_q816 = SCALE_RESET;

    // The display stays dark until the first tick, and the three-position scan wraps on the fourth tick.
    add_item(ACTION_SAMPLE, '0);
    add_item(ACTION_SAMPLE, '1);
    add_item(ACTION_SAMPLE, 10'h2AA);
    add_item(ACTION_SAMPLE, 10'h155);
    add_item(ACTION_TICK, '1);
    add_item(ACTION_TICK, '0);
    add_item(ACTION_TICK, 10'h2AA);
    add_item(ACTION_TICK, 10'h155);

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: s = SCALE_RESET;
        1: s = '0;
        2: s = '1;
        3: s = 24'd65536;
        4: s = 24'd64000;
        5: s = SCALE_W'($urandom_range(0, 24'hFFFFFF));
        6: s = SCALE_W'($urandom_range(3000, 70000));
        7: s = SCALE_W'($urandom_range(30000, 70000));
        default: s = SCALE_RESET;
      endcase
      add_control(JOB_SCALE, s, 1'b0);
      add_control(JOB_IDLING, '0, (p % 3) != 2);
      add_window(fill_t'((p * 2) % 4));
      add_control(JOB_PAUSE, '0, 1'b0);
      add_window(fill_t'($urandom_range(0, 3)));
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (jobs.size() != 0 || in_valid || cfg_valid || expected_readouts.size() != 0) begin
      @(posedge clk);
    end
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("averaging_panel_meter_display test passed");
    end else begin
      $display("averaging_panel_meter_display test failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("averaging_panel_meter_display test failed");
    $finish;
  end

  always @(negedge clk) begin : drive_inputs
    logic               nxt_valid;
    logic               nxt_cfg_valid;
    in_t                nxt_data;
    logic [SCALE_W-1:0] nxt_cfg_data;
    if (!rst) begin
      nxt_valid = in_valid;
      nxt_data = in_data;
      nxt_cfg_valid = cfg_valid;
      nxt_cfg_data = cfg_data;
      if (in_valid && n_in_taken == n_in_sent) begin
        nxt_valid = 1'b0;
      end
      if (cfg_valid && n_cfg_taken == n_cfg_sent) begin
        nxt_cfg_valid = 1'b0;
      end
      if (!nxt_valid && !nxt_cfg_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (jobs.size() != 0) begin
          case (jobs[0].kind)
            JOB_ITEM: begin
              nxt_valid = 1'b1;
              nxt_data = jobs[0].item;
              n_in_sent++;
              in_gap = idling_on ? $urandom_range(0, 8) : 0;
              void'(jobs.pop_front());
            end
            JOB_SCALE: begin
              if (expected_readouts.size() == 0) begin
                nxt_cfg_valid = 1'b1;
                nxt_cfg_data = jobs[0].scale;
                n_cfg_sent++;
                in_gap = idling_on ? $urandom_range(0, 8) : 0;
                void'(jobs.pop_front());
              end
            end
            JOB_PAUSE: begin
              if (expected_readouts.size() == 0) begin
                void'(jobs.pop_front());
              end
            end
            default: begin
              idling_on = jobs[0].idling;
              void'(jobs.pop_front());
            end
          endcase
        end
      end
      in_valid <= nxt_valid;
      in_data <= nxt_data;
      cfg_valid <= nxt_cfg_valid;
      cfg_data <= nxt_cfg_data;
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (n_out_taken != n_out_seen) begin
        n_out_seen = n_out_taken;
        out_stall = idling_on ? $urandom_range(0, 8) : 0;
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watch_outputs
    out_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_readouts.push_back(meter_response(in_data));
        n_in_taken++;
      end
      if (cfg_valid && cfg_ready) begin
        scale_q816 = cfg_data;
        n_cfg_taken++;
      end
      if (out_valid && out_ready) begin
        n_out_taken++;
        if (expected_readouts.size() == 0) begin
          flag_mismatch("unexpected transaction", 32'(out_data), '0);
        end else begin
          want = expected_readouts.pop_front();
          if (out_data.display_digit !== want.display_digit) begin
            flag_mismatch("display_digit", 32'(out_data.display_digit),
                          32'(want.display_digit));
          end
          if (out_data.digit_enable !== want.digit_enable) begin
            flag_mismatch("digit_enable", 32'(out_data.digit_enable),
                          32'(want.digit_enable));
          end
          if (out_data.reading !== want.reading) begin
            flag_mismatch("reading", 32'(out_data.reading), 32'(want.reading));
          end
          if (out_data.new_reading !== want.new_reading) begin
            flag_mismatch("new_reading", 32'(out_data.new_reading),
                          32'(want.new_reading));
          end
        end
      end
    end
  end

endmodule
